FILE: design/kapwm_pkg.sv
// Shared types and constants of the keypad adjusted PWM generator.
// No dependencies; the top level, kapwm_cfg, kapwm_phase_calc and kapwm_core refer to it by scoped names.
package kapwm_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int LIMIT_W    = 12;
  localparam int PCFG_W     = 16;
  localparam int DUTY_W     = 7;
  localparam int BTN_W      = 3;

  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
  localparam int PERIOD_RESET = 10000;

  localparam logic [LIMIT_W-1:0] RIGHT_RESET  = 12'd400;
  localparam logic [LIMIT_W-1:0] UP_RESET     = 12'd1000;
  localparam logic [LIMIT_W-1:0] DOWN_RESET   = 12'd1500;
  localparam logic [LIMIT_W-1:0] LEFT_RESET   = 12'd2000;
  localparam logic [LIMIT_W-1:0] SELECT_RESET = 12'd2500;
  localparam logic [PCFG_W-1:0]  FLOOR_RESET  = 16'd50;
  localparam logic [PCFG_W-1:0]  CEIL_RESET   = 16'd50000;
  localparam logic [PCFG_W-1:0]  STEP_RESET   = 16'd100;

  // register indexes (byte address / 4)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RIGHT_LIMIT    = 3'd0;
  localparam reg_idx_t REG_UP_LIMIT       = 3'd1;
  localparam reg_idx_t REG_DOWN_LIMIT     = 3'd2;
  localparam reg_idx_t REG_LEFT_LIMIT     = 3'd3;
  localparam reg_idx_t REG_SELECT_LIMIT   = 3'd4;
  localparam reg_idx_t REG_PERIOD_FLOOR   = 3'd5;
  localparam reg_idx_t REG_PERIOD_CEILING = 3'd6;
  localparam reg_idx_t REG_PERIOD_STEP    = 3'd7;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef enum logic [BTN_W-1:0] {
    BTN_NONE   = 3'd0,
    BTN_UP     = 3'd1,
    BTN_DOWN   = 3'd2,
    BTN_LEFT   = 3'd3,
    BTN_RIGHT  = 3'd4,
    BTN_SELECT = 3'd5
  } button_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] right_limit;
    logic [LIMIT_W-1:0] up_limit;
    logic [LIMIT_W-1:0] down_limit;
    logic [LIMIT_W-1:0] left_limit;
    logic [LIMIT_W-1:0] select_limit;
    logic [PCFG_W-1:0]  period_floor;
    logic [PCFG_W-1:0]  period_ceiling;
    logic [PCFG_W-1:0]  period_step;
  } cfg_t;

endpackage

FILE: design/kapwm_item_if.sv
// Input channel of the keypad adjusted PWM generator: tick or button scan item.
// Standalone interface; no package dependency.
interface kapwm_item_if #(
  parameter int ADC_BITS = 12
) ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output op, output adc_sample, input ready);
  modport sink   (input valid, input op, input adc_sample, output ready);
endinterface

FILE: design/kapwm_result_if.sv
// Output channel of the keypad adjusted PWM generator: one result per item.
// Standalone interface; no package dependency.
interface kapwm_result_if #(
  parameter int PERIOD_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic                   pin_level;
  logic [2:0]             button_code;
  logic [PERIOD_BITS-1:0] period_now;
  logic [6:0]             duty_now;

  modport source (output valid, output pin_level, output button_code,
                  output period_now, output duty_now, input ready);
  modport sink   (input valid, input pin_level, input button_code,
                  input period_now, input duty_now, output ready);
endinterface

FILE: design/keypad_adjusted_pwm_generator_top.sv
// Top level of the keypad adjusted PWM generator.
// Depends on kapwm_pkg, kapwm_item_if, kapwm_result_if, kapwm_cfg,
// kapwm_phase_calc and kapwm_core.
//
// Each accepted item gives one result, which appears in the output register in
// the cycle after the item is taken; a new item can be taken in every cycle,
// ticks and button scans alike. The input stalls only while a result is held
// and the result side is not ready. The PWM phases are followed by counting
// ticks through the period and comparing 100 times the count with period*duty,
// both taken at the period start, so a scan's new settings apply from the next
// period start. Configuration writes take effect at the next item; make them
// while no item is in flight.
module keypad_adjusted_pwm_generator_top #(
  parameter int ADC_BITS    = 12,
  parameter int PERIOD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  kapwm_item_if.sink                       item,
  kapwm_result_if.source                   result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kapwm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kapwm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kapwm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  kapwm_pkg::cfg_t              cfg;
  logic                         tick;
  logic                         period_start;
  logic                         level_next;
  logic [PERIOD_BITS-1:0]       period_setting;
  logic [kapwm_pkg::DUTY_W-1:0] duty_setting;

  kapwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kapwm_phase_calc #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_phase_calc (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .period       (period_setting),
    .duty         (duty_setting),
    .period_start (period_start),
    .level_next   (level_next)
  );

  kapwm_core #(
    .ADC_BITS    (ADC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .result         (result),
    .cfg            (cfg),
    .tick           (tick),
    .period_start   (period_start),
    .level_next     (level_next),
    .period_setting (period_setting),
    .duty_setting   (duty_setting)
  );

endmodule

FILE: design/kapwm_cfg.sv
// APB-style configuration registers: keypad thresholds and period limits.
// Depends on kapwm_pkg.
module kapwm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kapwm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [kapwm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [kapwm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready,
  output kapwm_pkg::cfg_t                    cfg
);

  kapwm_pkg::reg_idx_t idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_limit    <= kapwm_pkg::RIGHT_RESET;
      cfg.up_limit       <= kapwm_pkg::UP_RESET;
      cfg.down_limit     <= kapwm_pkg::DOWN_RESET;
      cfg.left_limit     <= kapwm_pkg::LEFT_RESET;
      cfg.select_limit   <= kapwm_pkg::SELECT_RESET;
      cfg.period_floor   <= kapwm_pkg::FLOOR_RESET;
      cfg.period_ceiling <= kapwm_pkg::CEIL_RESET;
      cfg.period_step    <= kapwm_pkg::STEP_RESET;
    end else if (wr) begin
      case (idx)
        kapwm_pkg::REG_RIGHT_LIMIT:    cfg.right_limit    <= pwdata[11:0];
        kapwm_pkg::REG_UP_LIMIT:       cfg.up_limit       <= pwdata[11:0];
        kapwm_pkg::REG_DOWN_LIMIT:     cfg.down_limit     <= pwdata[11:0];
        kapwm_pkg::REG_LEFT_LIMIT:     cfg.left_limit     <= pwdata[11:0];
        kapwm_pkg::REG_SELECT_LIMIT:   cfg.select_limit   <= pwdata[11:0];
        kapwm_pkg::REG_PERIOD_FLOOR:   cfg.period_floor   <= pwdata[15:0];
        kapwm_pkg::REG_PERIOD_CEILING: cfg.period_ceiling <= pwdata[15:0];
        kapwm_pkg::REG_PERIOD_STEP:    cfg.period_step    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kapwm_pkg::REG_RIGHT_LIMIT:    prdata = 32'(cfg.right_limit);
      kapwm_pkg::REG_UP_LIMIT:       prdata = 32'(cfg.up_limit);
      kapwm_pkg::REG_DOWN_LIMIT:     prdata = 32'(cfg.down_limit);
      kapwm_pkg::REG_LEFT_LIMIT:     prdata = 32'(cfg.left_limit);
      kapwm_pkg::REG_SELECT_LIMIT:   prdata = 32'(cfg.select_limit);
      kapwm_pkg::REG_PERIOD_FLOOR:   prdata = 32'(cfg.period_floor);
      kapwm_pkg::REG_PERIOD_CEILING: prdata = 32'(cfg.period_ceiling);
      kapwm_pkg::REG_PERIOD_STEP:    prdata = 32'(cfg.period_step);
      default:                       prdata = '0;
    endcase
  end

endmodule

FILE: design/kapwm_phase_calc.sv
// Phase tracker: counts ticks through the PWM period and sets the pin level.
// Uses kapwm_pkg.
module kapwm_phase_calc #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick,
  input  logic [PERIOD_BITS-1:0]         period,
  input  logic [kapwm_pkg::DUTY_W-1:0]   duty,
  output logic                           period_start,
  output logic                           level_next
);

  localparam int XW = PERIOD_BITS + kapwm_pkg::DUTY_W;

  logic [PERIOD_BITS-1:0] count, count_next;
  logic [PERIOD_BITS-1:0] per_hold, per_hold_next;
  logic [XW-1:0]          scaled, scaled_next;
  logic [XW-1:0]          prod_hold, prod_hold_next;
  logic                   level;
  logic [XW-1:0]          prod;

  assign prod = XW'(period) * XW'(duty);

  // the period is spent once the tick count reaches the period taken at its start
  assign period_start = (count >= per_hold);

  // tick k of a period is high while 100*k <= period*duty, i.e. k <= period*duty/100
  always_comb begin
    count_next     = count;
    per_hold_next  = per_hold;
    scaled_next    = scaled;
    prod_hold_next = prod_hold;
    level_next     = level;
    if (tick) begin
      if (period_start) begin
        count_next     = PERIOD_BITS'(1);
        per_hold_next  = period;
        scaled_next    = XW'(kapwm_pkg::DUTY_MAX);
        prod_hold_next = prod;
      end else begin
        count_next  = count + PERIOD_BITS'(1);
        scaled_next = scaled + XW'(kapwm_pkg::DUTY_MAX);
      end
      level_next = (scaled_next <= prod_hold_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      per_hold  <= '0;
      scaled    <= '0;
      prod_hold <= '0;
      level     <= 1'b0;
    end else begin
      count     <= count_next;
      per_hold  <= per_hold_next;
      scaled    <= scaled_next;
      prod_hold <= prod_hold_next;
      level     <= level_next;
    end
  end

  a_count_in_period: assert property (@(posedge clk) disable iff (rst)
    per_hold != '0 |-> count <= per_hold)
    else $error("tick count beyond the period");

  a_scaled_tracks_count: assert property (@(posedge clk) disable iff (rst)
    scaled == XW'(count) * XW'(kapwm_pkg::DUTY_MAX))
    else $error("scaled count out of step with the tick count");

  a_empty_high_phase_low: assert property (@(posedge clk) disable iff (rst)
    tick && period_start && prod == '0 |-> !level_next)
    else $error("pin high in a period with no high phase");

endmodule

FILE: design/kapwm_core.sv
// Item processing: keypad decode, period/duty settings and the result register.
// Depends on kapwm_pkg and the two channel interfaces.
module kapwm_core #(
  parameter int ADC_BITS    = 12,
  parameter int PERIOD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  kapwm_item_if.sink                     item,
  kapwm_result_if.source                 result,
  input  kapwm_pkg::cfg_t                cfg,
  output logic                           tick,
  input  logic                           period_start,
  input  logic                           level_next,
  output logic [PERIOD_BITS-1:0]         period_setting,
  output logic [kapwm_pkg::DUTY_W-1:0]   duty_setting
);

  localparam int AW = (ADC_BITS > kapwm_pkg::LIMIT_W) ? ADC_BITS : kapwm_pkg::LIMIT_W;
  localparam int SW = ((PERIOD_BITS > kapwm_pkg::PCFG_W) ? PERIOD_BITS
                                                          : kapwm_pkg::PCFG_W) + 1;

  logic                   change_pending;

  logic                   change_pending_next;
  logic [PERIOD_BITS-1:0] period_setting_next;
  logic [kapwm_pkg::DUTY_W-1:0] duty_setting_next;

  logic                   accept;
  logic                   is_scan;
  kapwm_pkg::button_t     btn;
  logic [AW-1:0]          sample;
  logic [SW-1:0]          per_w, floor_w, ceil_w, step_w;

  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign is_scan    = (item.op == kapwm_pkg::OP_SCAN);
  assign tick       = accept && !is_scan;

  assign sample  = AW'(item.adc_sample);
  assign per_w   = SW'(period_setting);
  assign floor_w = SW'(cfg.period_floor);
  assign ceil_w  = SW'(cfg.period_ceiling);
  assign step_w  = SW'(cfg.period_step);

  // ladder decode: thresholds are tested in register order, right first and select last
  always_comb begin
    if (!is_scan) begin
      btn = kapwm_pkg::BTN_NONE;
    end else if (sample < AW'(cfg.right_limit)) begin
      btn = kapwm_pkg::BTN_RIGHT;
    end else if (sample < AW'(cfg.up_limit)) begin
      btn = kapwm_pkg::BTN_UP;
    end else if (sample < AW'(cfg.down_limit)) begin
      btn = kapwm_pkg::BTN_DOWN;
    end else if (sample < AW'(cfg.left_limit)) begin
      btn = kapwm_pkg::BTN_LEFT;
    end else if (sample < AW'(cfg.select_limit)) begin
      btn = kapwm_pkg::BTN_SELECT;
    end else begin
      btn = kapwm_pkg::BTN_NONE;
    end
  end

  always_comb begin
    period_setting_next = period_setting;
    duty_setting_next   = duty_setting;
    case (btn)
      kapwm_pkg::BTN_RIGHT: begin
        if (duty_setting < kapwm_pkg::DUTY_MAX) begin
          duty_setting_next = duty_setting + 7'd1;
        end
      end
      kapwm_pkg::BTN_LEFT: begin
        if (duty_setting != '0) begin
          duty_setting_next = duty_setting - 7'd1;
        end
      end
      kapwm_pkg::BTN_UP: begin
        if (per_w >= floor_w + step_w) begin
          period_setting_next = PERIOD_BITS'(per_w - step_w);
        end else begin
          period_setting_next = PERIOD_BITS'(floor_w);
        end
      end
      kapwm_pkg::BTN_DOWN: begin
        if (per_w + step_w <= ceil_w) begin
          period_setting_next = PERIOD_BITS'(per_w + step_w);
        end else begin
          period_setting_next = PERIOD_BITS'(ceil_w);
        end
      end
      default: ;
    endcase
  end

  // mark a press as pending, drop it when a period starts
  always_comb begin
    change_pending_next = change_pending;
    if (is_scan) begin
      if (btn != kapwm_pkg::BTN_NONE) begin
        change_pending_next = 1'b1;
      end
    end else if (period_start) begin
      change_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_setting  <= PERIOD_BITS'(kapwm_pkg::PERIOD_RESET);
      duty_setting    <= kapwm_pkg::DUTY_RESET;
      change_pending  <= 1'b1;
      result.valid    <= 1'b0;
    end else begin
      if (accept) begin
        period_setting  <= period_setting_next;
        duty_setting    <= duty_setting_next;
        change_pending  <= change_pending_next;
        result.valid    <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.pin_level   <= level_next;
      result.button_code <= btn;
      result.period_now  <= period_setting_next;
      result.duty_now    <= duty_setting_next;
    end
  end

  a_period_start_clears_pending: assert property (@(posedge clk) disable iff (rst)
    accept && !is_scan && period_start |=> !change_pending)
    else $error("period start did not clear the pending change");

  a_press_sets_pending: assert property (@(posedge clk) disable iff (rst)
    accept && btn != kapwm_pkg::BTN_NONE |=> change_pending)
    else $error("button press did not mark a pending change");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input stalled with the result register empty");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    duty_setting <= kapwm_pkg::DUTY_MAX)
    else $error("duty setting above 100");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted item produced no result");

endmodule

FILE: tb/sv/kapwm_pwm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the keypad adjusted PWM generator: follows the config writes,
// predicts one readout per accepted tick or scan item and compares it in order.
// Depends on kapwm_pkg, kapwm_item_if and kapwm_result_if.
module kapwm_pwm_checker (
  input  logic                             clk,
  input  logic                             rst,
  kapwm_item_if                            item,
  kapwm_result_if                          result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [kapwm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kapwm_pkg::CFG_DATA_W-1:0] pwdata,
  output int                               failures,
  output int                               outstanding
);
  import kapwm_pkg::*;

  typedef struct packed {
    logic        pin;
    button_t     btn;
    logic [15:0] period;
    logic [6:0]  duty;
  } readout_t;

  readout_t readouts_due[$];
  int mismatch_count = 0;
  int readout_index  = 0;

  logic [LIMIT_W-1:0] right_lim, up_lim, down_lim, left_lim, select_lim;
  logic [PCFG_W-1:0]  floor_us, ceil_us, step_us;

  logic [15:0]       period_us;
  logic [DUTY_W-1:0] duty_pct;
  logic              high_phase;
  logic [15:0]       phase_left;
  logic [15:0]       low_len;

  assign failures = mismatch_count;

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: %s", $time, what);
  endtask

  function automatic button_t decode_sample(logic [LIMIT_W-1:0] s);
    if (s < right_lim) return BTN_RIGHT;
    if (s < up_lim) return BTN_UP;
    if (s < down_lim) return BTN_DOWN;
    if (s < left_lim) return BTN_LEFT;
    if (s < select_lim) return BTN_SELECT;
    return BTN_NONE;
  endfunction

  // sample the settings: high part first, low part skipped straight to if empty
  function automatic void begin_period();
    logic [31:0] on_len;
    on_len  = (32'(period_us) * 32'(duty_pct)) / 32'd100;
    low_len = period_us - on_len[15:0];
    if (on_len != 0) begin
      high_phase = 1'b1;
      phase_left = on_len[15:0];
    end else begin
      high_phase = 1'b0;
      phase_left = low_len;
    end
  endfunction

  function automatic void count_tick();
    if (phase_left == 0) begin
      if (high_phase) begin
        high_phase = 1'b0;
        phase_left = low_len;
        if (phase_left == 0) begin_period();
      end else begin
        begin_period();
      end
    end
    if (phase_left != 0) phase_left = phase_left - 16'd1;
  endfunction

  // sums are taken one bit wider so that nothing wraps
  function automatic void apply_press(button_t b);
    logic [16:0] wide;
    case (b)
      BTN_RIGHT: begin
        if (duty_pct < DUTY_MAX) duty_pct = duty_pct + 7'd1;
      end
      BTN_LEFT: begin
        if (duty_pct != 0) duty_pct = duty_pct - 7'd1;
      end
      BTN_UP: begin
        wide = 17'(floor_us) + 17'(step_us);
        if (17'(period_us) >= wide) period_us = period_us - step_us;
        else period_us = floor_us;
      end
      BTN_DOWN: begin
        wide = 17'(period_us) + 17'(step_us);
        if (wide <= 17'(ceil_us)) period_us = wide[15:0];
        else period_us = ceil_us;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    readout_t due, seen;
    if (rst) begin
      right_lim   = RIGHT_RESET;
      up_lim      = UP_RESET;
      down_lim    = DOWN_RESET;
      left_lim    = LEFT_RESET;
      select_lim  = SELECT_RESET;
      floor_us    = FLOOR_RESET;
      ceil_us     = CEIL_RESET;
      step_us     = STEP_RESET;
      period_us   = 16'(PERIOD_RESET);
      duty_pct    = DUTY_RESET;
      high_phase  = 1'b0;
      phase_left  = '0;
      low_len     = '0;
      readouts_due.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_RIGHT_LIMIT:    right_lim  = pwdata[LIMIT_W-1:0];
          REG_UP_LIMIT:       up_lim     = pwdata[LIMIT_W-1:0];
          REG_DOWN_LIMIT:     down_lim   = pwdata[LIMIT_W-1:0];
          REG_LEFT_LIMIT:     left_lim   = pwdata[LIMIT_W-1:0];
          REG_SELECT_LIMIT:   select_lim = pwdata[LIMIT_W-1:0];
          REG_PERIOD_FLOOR:   floor_us   = pwdata[PCFG_W-1:0];
          REG_PERIOD_CEILING: ceil_us    = pwdata[PCFG_W-1:0];
          REG_PERIOD_STEP:    step_us    = pwdata[PCFG_W-1:0];
          default: ;
        endcase
      end

      if (item.valid && item.ready) begin
        due.btn = BTN_NONE;
        if (item.op == OP_TICK) begin
          count_tick();
        end else begin
          due.btn = decode_sample(item.adc_sample);
          apply_press(due.btn);
        end
        due.pin    = high_phase;
        due.period = period_us;
        due.duty   = duty_pct;
        readouts_due.push_back(due);
      end

      if (result.valid && result.ready) begin
        seen.pin    = result.pin_level;
        seen.btn    = button_t'(result.button_code);
        seen.period = result.period_now;
        seen.duty   = result.duty_now;
        if (readouts_due.size() == 0) begin
          flag_mismatch($sformatf("readout %0d arrived with none due", readout_index));
        end else begin
          due = readouts_due.pop_front();
          if (seen !== due)
            flag_mismatch($sformatf(
              "readout %0d: pin %0b btn %0d period %0d duty %0d, want %0b %0d %0d %0d",
              readout_index, seen.pin, seen.btn, seen.period, seen.duty,
              due.pin, due.btn, due.period, due.duty));
        end
        readout_index++;
      end
      outstanding <= readouts_due.size();
    end
  end

endmodule

FILE: tb/sv/keypad_adjusted_pwm_generator_top_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the keypad adjusted PWM generator: tick runs and
// button scan bursts under several register settings, checked by kapwm_pwm_checker.
// Depends on kapwm_pkg, both channel interfaces and the generator top level.
module keypad_adjusted_pwm_generator_top_tb;
  import kapwm_pkg::*;

  logic clk;
  logic rst = 1'b1;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int   failures, outstanding;
  bit   quiet_end = 1'b0;

  // thresholds as last written, used to aim samples at a chosen button
  logic [LIMIT_W-1:0] limit_set [5];

  kapwm_item_if   #(.ADC_BITS(12))    item_ch ();
  kapwm_result_if #(.PERIOD_BITS(16)) result_ch ();

  keypad_adjusted_pwm_generator_top #(.ADC_BITS(12), .PERIOD_BITS(16)) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kapwm_pwm_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("keypad_adjusted_pwm_generator_top: mismatch");
    $finish;
  end

  // result side: random stall bursts until the quiet tail
  initial begin : receiver
    result_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet_end && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic op, logic [11:0] sample);
    if (!quiet_end && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.adc_sample <= sample;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // pick a sample that decodes to b under the current thresholds, edges often; random if b has no band
  function automatic logic [11:0] sample_for(button_t b);
    int pos, lo, hi;
    case (b)
      BTN_RIGHT:  pos = int'(REG_RIGHT_LIMIT);
      BTN_UP:     pos = int'(REG_UP_LIMIT);
      BTN_DOWN:   pos = int'(REG_DOWN_LIMIT);
      BTN_LEFT:   pos = int'(REG_LEFT_LIMIT);
      BTN_SELECT: pos = int'(REG_SELECT_LIMIT);
      default:    pos = int'(REG_SELECT_LIMIT) + 1;
    endcase
    lo = 0;
    for (int i = 0; i < pos; i++)
      if (int'(limit_set[i]) > lo) lo = int'(limit_set[i]);
    hi = (pos > int'(REG_SELECT_LIMIT)) ? 4095 : int'(limit_set[pos]) - 1;
    if (lo > hi) return 12'($urandom);
    case ($urandom_range(0, 3))
      0:       return 12'(lo);
      1:       return 12'(hi);
      default: return 12'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic configure(input logic [11:0] right_v, up_v, down_v, left_v, select_v,
                           input logic [15:0] floor_v, ceil_v, step_v);
    logic [15:0] plan [8];
    logic [31:0] word;
    drain();
    plan[REG_RIGHT_LIMIT]    = 16'(right_v);
    plan[REG_UP_LIMIT]       = 16'(up_v);
    plan[REG_DOWN_LIMIT]     = 16'(down_v);
    plan[REG_LEFT_LIMIT]     = 16'(left_v);
    plan[REG_SELECT_LIMIT]   = 16'(select_v);
    plan[REG_PERIOD_FLOOR]   = floor_v;
    plan[REG_PERIOD_CEILING] = ceil_v;
    plan[REG_PERIOD_STEP]    = step_v;
    for (int i = 0; i < 8; i++) begin
      // junk in the unused upper bits must be dropped
      word = $urandom;
      if (reg_idx_t'(i) <= REG_SELECT_LIMIT) begin
        word[LIMIT_W-1:0] = plan[i][LIMIT_W-1:0];
        limit_set[i]      = plan[i][LIMIT_W-1:0];
      end else begin
        word[PCFG_W-1:0] = plan[i];
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(i), 2'b00};
      pwdata  <= word;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly tick runs long enough to cross periods, mixed with press bursts
  task automatic run_mix(int budget);
    int sent, run, kind;
    button_t b;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        run = $urandom_range(1, 60);
        repeat (run) send_item(OP_TICK, 12'($urandom));
      end else if (kind < 16) begin
        b   = button_t'(3'($urandom_range(int'(BTN_NONE), int'(BTN_SELECT))));
        run = $urandom_range(1, 6);
        repeat (run) send_item(OP_SCAN, sample_for(b));
      end else if (kind < 17) begin
        // long duty sweep towards an end stop
        b   = $urandom_range(0, 1) ? BTN_LEFT : BTN_RIGHT;
        run = $urandom_range(20, 60);
        repeat (run) send_item(OP_SCAN, sample_for(b));
      end else begin
        run = 1;
        send_item(OP_SCAN, 12'($urandom));
      end
      sent += run;
    end
  endtask

  initial begin : stimulus
    logic [11:0] probes [14];
    int unsigned cut [5];
    probes = '{12'd0, 12'd399, 12'd400, 12'd999, 12'd1000, 12'd1499, 12'd1500,
               12'd1999, 12'd2000, 12'd2499, 12'd2500, 12'd4095, 12'hAAA, 12'h555};
    item_ch.valid      <= 1'b0;
    item_ch.op         <= OP_TICK;
    item_ch.adc_sample <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    limit_set = '{RIGHT_RESET, UP_RESET, DOWN_RESET, LEFT_RESET, SELECT_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first ticks start a period, then every threshold edge
    repeat (3) send_item(OP_TICK, 12'hFFF);
    foreach (probes[i]) send_item(OP_SCAN, probes[i]);
    repeat (3) send_item(OP_TICK, 12'h000);
    run_mix(80);

    // short periods so the pin toggles often
    configure(RIGHT_RESET, UP_RESET, DOWN_RESET, LEFT_RESET, SELECT_RESET,
              16'd1, 16'd40, 16'd3);
    run_mix(130);

    // only select or none; full-scale step saturates both ways
    configure(12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 16'd1, 16'hFFFF, 16'hFFFF);
    run_mix(80);

    // floor above ceiling, one-code button bands
    configure(12'd1, 12'd2, 12'd3, 12'd4, 12'd4095, 16'hFFFF, 16'd8, 16'd1);
    run_mix(110);

    cut[0] = $urandom_range(0, 800);
    for (int i = 1; i < 5; i++) cut[i] = cut[i-1] + $urandom_range(0, 800);
    configure(12'(cut[0]), 12'(cut[1]), 12'(cut[2]), 12'(cut[3]), 12'(cut[4]),
              16'($urandom_range(1, 20)), 16'($urandom_range(1, 60)),
              16'($urandom_range(1, 16)));
    run_mix(100);

    // thresholds in no particular order
    configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)),
              16'($urandom_range(1, 65535)));
    run_mix(100);

    configure(RIGHT_RESET, UP_RESET, DOWN_RESET, LEFT_RESET, SELECT_RESET,
              16'd2, 16'd25, 16'd2);
    quiet_end = 1'b1;
    run_mix(120);

    drain();
    repeat (32) @(posedge clk);
    if (failures == 0) begin
      $display("keypad_adjusted_pwm_generator_top: match");
    end else begin
      $display("keypad_adjusted_pwm_generator_top: mismatch");
    end
    $finish;
  end

endmodule
